// ===== rtl/pwg_pkg.sv =====
package pwg_pkg;

    localparam int SINE_FRAC_BITS = 16;

    localparam int POS_W   = 10;
    localparam int IDX_W   = 9;
    localparam int CS_W    = 10;
    localparam int LEVEL_W = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_KIND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET = 3'd4;

    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_SAW      = 2'd1;
    localparam logic [1:0] SHAPE_PARABOLA = 2'd2;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic [1:0] wave_kind;
        logic [7:0] peak_level;
        logic [8:0] cycle_count;
        logic [8:0] phase_offset;
        logic [7:0] level_offset;
    } t_cfg;

    // handed from the index pipe to the wave pipe
    typedef struct packed {
        logic                    oor;
        logic [IDX_W-1:0]        p;
        logic                    neg;
        logic [SINE_FRAC_BITS:0] s;
    } t_idx;

    typedef logic [SINE_FRAC_BITS:0] t_sine;
    typedef t_sine t_sine_tab [129];
    typedef logic [CS_W-1:0] t_cs_tab [256];

    function automatic logic [8:0] eff_cycles(input logic [8:0] c);
        logic [8:0] r;
        r = (c == 9'd0) ? 9'd1 : c;
        return r;
    endfunction

    // one restoring step of q mod cs
    function automatic logic [CS_W-1:0] rem_step(input logic [CS_W-1:0] r,
                                                 input logic [CS_W-1:0] cs,
                                                 input int sh);
        logic [2*CS_W-1:0] d;
        logic [CS_W-1:0]   res;
        d = {{CS_W{1'b0}}, cs} << sh;
        if ({{CS_W{1'b0}}, r} >= d) begin
            res = r - d[CS_W-1:0];
        end else begin
            res = r;
        end
        return res;
    endfunction

    // quarter wave sine, taylor series in q2.30, rounded to the table precision
    function automatic t_sine sine_level(input int k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        s;
        logic signed [63:0] sum;
        x    = (64'(k) * PI_Q30) >> 8;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd420; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd506; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd600; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        s = ($unsigned(sum) + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
        if (s > (64'd1 << SINE_FRAC_BITS)) begin
            s = 64'd1 << SINE_FRAC_BITS;
        end
        return s[SINE_FRAC_BITS:0];
    endfunction

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab t;
        for (int k = 0; k < 129; k++) begin
            t[k] = sine_level(k);
        end
        return t;
    endfunction

    // cycle size 512 / n for n = 1..256, by counting multiples
    function automatic t_cs_tab build_cs_tab();
        t_cs_tab t;
        int      q;
        for (int i = 0; i < 256; i++) begin
            q = 0;
            for (int m = 1; m <= 512; m++) begin
                if (m * (i + 1) <= 512) begin
                    q = m;
                end
            end
            t[i] = CS_W'(q);
        end
        return t;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();
    localparam t_cs_tab   CS_TAB   = build_cs_tab();

endpackage

// ===== rtl/pwg_cfg_regs.sv =====
module pwg_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pwg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pwg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output pwg_pkg::t_cfg                      o_cfg
);

    pwg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_kind    <= pwg_pkg::SHAPE_SINE;
            r_cfg.peak_level   <= 8'd255;
            r_cfg.cycle_count  <= 9'd1;
            r_cfg.phase_offset <= 9'd0;
            r_cfg.level_offset <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pwg_pkg::REG_WAVE_KIND:    r_cfg.wave_kind    <= i_cfg_data[1:0];
                pwg_pkg::REG_PEAK_LEVEL:   r_cfg.peak_level   <= i_cfg_data[7:0];
                pwg_pkg::REG_CYCLE_COUNT:  r_cfg.cycle_count  <= i_cfg_data[8:0];
                pwg_pkg::REG_PHASE_OFFSET: r_cfg.phase_offset <= i_cfg_data[8:0];
                pwg_pkg::REG_LEVEL_OFFSET: r_cfg.level_offset <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pwg_index.sv =====
module pwg_index (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pwg_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    input  logic [pwg_pkg::POS_W-1:0]     i_position,
    output logic                          o_ready,
    output logic                          o_valid,
    output pwg_pkg::t_idx                 o_idx,
    input  logic                          i_ready
);

    localparam int CW = pwg_pkg::CS_W;

    logic [8:0] cyc;
    logic       ce1, ce2, ce3;

    // stage 1: phase, cycle size
    logic          r_v1, r_oor1;
    logic [CW-1:0] r_q1, r_cs1;
    logic [8:0]    j;
    logic [CW-1:0] n_q1, n_cs1;

    // stage 2: upper remainder steps, sine angle
    logic          r_v2, r_oor2;
    logic [CW-1:0] r_rem2, r_cs2;
    logic [8:0]    r_a2;
    logic [CW-1:0] n_rem2;
    logic [17:0]   ang;

    // stage 3: lower remainder steps, sine lookup
    logic          r_v3;
    pwg_pkg::t_idx r_idx3;
    logic [CW-1:0] n_rem3;
    logic [7:0]    k;

    assign cyc = pwg_pkg::eff_cycles(i_cfg.cycle_count);

    assign ce3     = !r_v3 || i_ready;
    assign ce2     = !r_v2 || ce3;
    assign ce1     = !r_v1 || ce2;
    assign o_ready = ce1;

    always_comb begin
        j    = i_position[8:0] + i_cfg.phase_offset;
        n_q1 = {1'b0, j} + {1'b0, i_cfg.phase_offset};
        // counts above 256 leave one entry per cycle
        if (cyc > 9'd256) begin
            n_cs1 = CW'(1);
        end else begin
            n_cs1 = pwg_pkg::CS_TAB[8'(cyc - 9'd1)];
        end
    end

    always_comb begin
        n_rem2 = r_q1;
        for (int i = 9; i >= 5; i--) begin
            n_rem2 = pwg_pkg::rem_step(n_rem2, r_cs1, i);
        end
        ang = cyc * r_q1[8:0];
    end

    always_comb begin
        n_rem3 = r_rem2;
        for (int i = 4; i >= 0; i--) begin
            n_rem3 = pwg_pkg::rem_step(n_rem3, r_cs2, i);
        end
        // second and fourth quadrants run the quarter table backwards
        if (r_a2[7]) begin
            k = 8'd128 - {1'b0, r_a2[6:0]};
        end else begin
            k = {1'b0, r_a2[6:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ce1) r_v1 <= i_valid;
            if (ce2) r_v2 <= r_v1;
            if (ce3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce1) begin
            r_oor1 <= i_position[9];
            r_q1   <= n_q1;
            r_cs1  <= n_cs1;
        end
        if (ce2) begin
            r_oor2 <= r_oor1;
            r_rem2 <= n_rem2;
            r_cs2  <= r_cs1;
            r_a2   <= ang[8:0];
        end
        if (ce3) begin
            r_idx3.oor <= r_oor2;
            r_idx3.p   <= n_rem3[8:0];
            r_idx3.neg <= r_a2[8];
            r_idx3.s   <= pwg_pkg::SINE_TAB[k];
        end
    end

    assign o_valid = r_v3;
    assign o_idx   = r_idx3;

endmodule

// ===== rtl/pwg_wave.sv =====
module pwg_wave (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pwg_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    input  pwg_pkg::t_idx                 i_idx,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [pwg_pkg::LEVEL_W-1:0]   o_level,
    input  logic                          i_ready
);

    localparam int F  = pwg_pkg::SINE_FRAC_BITS;
    localparam int BW = F + 2;
    localparam logic [BW-1:0] ONE = BW'(1) << F;

    logic [8:0] cyc;
    logic       ce4, ce5, ce6, ce7;

    // stage 4
    logic          r_v4, r_oor4;
    logic [8:0]    r_t4;
    logic [BW-1:0] r_base4;
    logic [17:0]   pc;

    // stage 5
    logic            r_v5, r_oor5;
    logic [16:0]     r_n5, r_sq5;
    logic [BW+7:0]   r_sp5;
    logic signed [9:0]  d;
    logic signed [19:0] dd;

    // stage 6
    logic          r_v6, r_oor6;
    logic [7:0]    r_w6, n_w6;
    logic [17:0]   saw_n;
    logic [24:0]   par;

    // stage 7
    logic          r_v7;
    logic [7:0]    r_level7;
    logic [8:0]    sum;

    assign cyc = pwg_pkg::eff_cycles(i_cfg.cycle_count);

    assign ce7     = !r_v7 || i_ready;
    assign ce6     = !r_v6 || ce7;
    assign ce5     = !r_v5 || ce6;
    assign ce4     = !r_v4 || ce5;
    assign o_ready = ce4;

    assign pc = i_idx.p * cyc;

    always_comb begin
        d  = $signed({1'b0, r_t4}) - 10'sd256;
        dd = d * d;
    end

    always_comb begin
        if (r_n5 > {1'b0, i_cfg.peak_level, 8'd0}) begin
            saw_n = {1'b0, i_cfg.peak_level, 9'd0} - {1'b0, r_n5};
        end else begin
            saw_n = {1'b0, r_n5};
        end
        par = r_sq5 * i_cfg.peak_level;
        case (i_cfg.wave_kind)
            pwg_pkg::SHAPE_SAW:      n_w6 = saw_n[15:8];
            pwg_pkg::SHAPE_PARABOLA: n_w6 = par[23:16];
            default:                 n_w6 = r_sp5[F+8:F+1];
        endcase
    end

    assign sum = {1'b0, r_w6} + {1'b0, i_cfg.level_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (ce4) r_v4 <= i_valid;
            if (ce5) r_v5 <= r_v4;
            if (ce6) r_v6 <= r_v5;
            if (ce7) r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce4) begin
            r_oor4  <= i_idx.oor;
            r_t4    <= pc[8:0];
            r_base4 <= i_idx.neg ? (ONE - BW'(i_idx.s)) : (ONE + BW'(i_idx.s));
        end
        if (ce5) begin
            r_oor5 <= r_oor4;
            r_n5   <= {8'd0, r_t4} * {9'd0, i_cfg.peak_level};
            r_sq5  <= dd[16:0];
            r_sp5  <= r_base4 * i_cfg.peak_level;
        end
        if (ce6) begin
            r_oor6 <= r_oor5;
            r_w6   <= n_w6;
        end
        if (ce7) begin
            // out-of-range positions give zero; fold sums past full scale back down
            if (r_oor6) begin
                r_level7 <= 8'd0;
            end else if (sum[8]) begin
                r_level7 <= ~sum[7:0];
            end else begin
                r_level7 <= sum[7:0];
            end
        end
    end

    assign o_valid = r_v7;
    assign o_level = r_level7;

endmodule

// ===== rtl/palette_waveform_generator_top.sv =====
// channel    dir  tdata bits (low first)        tuser  tlast
// s_axis     in   [9:0] position, [15:10] zero  -      -
// m_axis     out  [7:0] level                   -      -
// cfg        in   write enable, 3-bit index, 9-bit data
//
// one request per cycle sustained while m_axis does not stall
// the seven-stage pipe (index, remainder, sine lookup, then multiply and fold
// stages); each stage holds its own valid bit
// stalls on m_axis back up stage by stage, so empty stages still fill
// synchronous active-low reset clears the valid bits and loads register defaults
module palette_waveform_generator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [15:0]                        i_s_axis_tdata,   // [9:0] position
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [7:0]                         o_m_axis_tdata,   // [7:0] level
    input  logic                               i_cfg_we,
    input  logic [pwg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pwg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pwg_pkg::t_cfg cfg;
    pwg_pkg::t_idx idx;
    logic          idx_valid;
    logic          idx_ready;

    pwg_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pwg_index u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_s_axis_tvalid),
        .i_position (i_s_axis_tdata[pwg_pkg::POS_W-1:0]),
        .o_ready    (o_s_axis_tready),
        .o_valid    (idx_valid),
        .o_idx      (idx),
        .i_ready    (idx_ready)
    );

    pwg_wave u_wave (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (idx_valid),
        .i_idx   (idx),
        .o_ready (idx_ready),
        .o_valid (o_m_axis_tvalid),
        .o_level (o_m_axis_tdata),
        .i_ready (i_m_axis_tready)
    );

endmodule

// ===== rtl/pwg_checker.sv =====
module pwg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    a_stall_only_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output backpressure");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output request changed");

endmodule

bind palette_waveform_generator_top pwg_checker u_pwg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
